FILE: rtl/core/dovfq_pkg.sv
// Shared types, codes and scaling function of the dual output voltage fault qualifier.
package dovfq_pkg;

  localparam int SAMPLE_W = 12;
  localparam int VOLTS_W  = 10;
  localparam int DELAY_W  = 16;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0]          code_t;
  typedef logic [VOLTS_W-1:0]  volts_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [DELAY_W-1:0]  delay_t;
  typedef logic [TIME_W-1:0]   stamp_t;

  localparam code_t CODE_NONE  = 2'd0;
  localparam code_t CODE_VOLT  = 2'd1;
  localparam code_t CODE_SHORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CH1_OVER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CH1_UNDER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CH1_SHORT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CH2_OVER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CH2_SHORT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_DELAY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_DELAY = 3'd6;

  localparam volts_t RST_CH1_OVER    = 10'd550;
  localparam volts_t RST_CH1_UNDER   = 10'd150;
  localparam volts_t RST_CH1_SHORT   = 10'd30;
  localparam volts_t RST_CH2_OVER    = 10'd300;
  localparam volts_t RST_CH2_SHORT   = 10'd20;
  localparam delay_t RST_VOLT_DELAY  = 16'd1000;
  localparam delay_t RST_SHORT_DELAY = 16'd200;

  // floor(s*503/3000) as (s*M) >> 24, exact for every 12-bit s
  localparam int SCALE_SHIFT = 24;
  localparam int SCALE_MUL_W = 22;
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 22'd2812980;
  localparam int SCALE_PROD_W = SAMPLE_W + SCALE_MUL_W;

  typedef struct packed {
    code_t  fault;
    volts_t volts;
  } chan_res_t;

  function automatic volts_t scale_volts(input sample_t s);
    logic [SCALE_PROD_W-1:0] prod;
    prod = {{SCALE_MUL_W{1'b0}}, s} * {{SAMPLE_W{1'b0}}, SCALE_MUL};
    return prod[SCALE_SHIFT +: VOLTS_W];
  endfunction

endpackage

FILE: rtl/core/dual_output_voltage_fault_qualifier.sv
// Top level: config registers, request register, classification and result register.
//
// One request per clock sustained while out_ready is high. A request is captured in the input
// register, is classified and qualified against the channel state in one pass, and its result
// is registered in the result register once that register can take a new result.
// The input register frees up whenever the result register can take a new result, so a
// new request is accepted while a result still waits as long as the input register is
// empty. Configuration writes take effect on the next clock and must be made while idle.
module dual_output_voltage_fault_qualifier
  import dovfq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [11:0]           in_ch1_sample,
  input  logic [11:0]           in_ch2_sample,
  input  logic [31:0]           in_now_ms,
  input  logic                  in_system_started,
  input  logic                  in_regulator_active,
  input  logic                  in_ch1_enable,
  input  logic                  in_ch2_enable,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_ch1_fault,
  output logic [1:0]            out_ch2_fault,
  output logic [9:0]            out_ch1_volts,
  output logic [9:0]            out_ch2_volts
);

  volts_t ch1_over_r, ch1_under_r, ch1_short_r, ch2_over_r, ch2_short_r;
  delay_t volt_delay_r, short_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch1_over_r    <= RST_CH1_OVER;
      ch1_under_r   <= RST_CH1_UNDER;
      ch1_short_r   <= RST_CH1_SHORT;
      ch2_over_r    <= RST_CH2_OVER;
      ch2_short_r   <= RST_CH2_SHORT;
      volt_delay_r  <= RST_VOLT_DELAY;
      short_delay_r <= RST_SHORT_DELAY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CH1_OVER:    ch1_over_r    <= cfg_wdata[VOLTS_W-1:0];
        REG_CH1_UNDER:   ch1_under_r   <= cfg_wdata[VOLTS_W-1:0];
        REG_CH1_SHORT:   ch1_short_r   <= cfg_wdata[VOLTS_W-1:0];
        REG_CH2_OVER:    ch2_over_r    <= cfg_wdata[VOLTS_W-1:0];
        REG_CH2_SHORT:   ch2_short_r   <= cfg_wdata[VOLTS_W-1:0];
        REG_VOLT_DELAY:  volt_delay_r  <= cfg_wdata;
        REG_SHORT_DELAY: short_delay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic    req_valid_r;
  sample_t ch1_sample_r, ch2_sample_r;
  stamp_t  now_r;
  logic    run_r, ch1_en_r, ch2_en_r;
  logic    advance;

  assign advance  = req_valid_r && (!out_valid || out_ready);
  assign in_ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch1_sample_r <= in_ch1_sample;
      ch2_sample_r <= in_ch2_sample;
      now_r        <= in_now_ms;
      run_r        <= in_system_started && in_regulator_active;
      ch1_en_r     <= in_ch1_enable;
      ch2_en_r     <= in_ch2_enable;
    end
  end

  // classification
  volts_t ch1_v, ch2_v;
  code_t  ch1_cls, ch2_cls;

  assign ch1_v = scale_volts(ch1_sample_r);
  assign ch2_v = scale_volts(ch2_sample_r);

  always_comb begin
    if (ch1_v <= ch1_short_r) begin
      ch1_cls = CODE_SHORT;
    end else if (ch1_v >= ch1_over_r || ch1_v <= ch1_under_r) begin
      ch1_cls = CODE_VOLT;
    end else begin
      ch1_cls = CODE_NONE;
    end
    if (ch2_v >= ch2_over_r) begin
      ch2_cls = CODE_VOLT;
    end else if (ch2_v <= ch2_short_r) begin
      ch2_cls = CODE_SHORT;
    end else begin
      ch2_cls = CODE_NONE;
    end
  end

  chan_res_t ch1_res, ch2_res;

  dovfq_chan u_ch1 (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (advance && run_r && ch1_en_r),
    .cls         (ch1_cls),
    .volts       (ch1_v),
    .now_ms      (now_r),
    .volt_delay  (volt_delay_r),
    .short_delay (short_delay_r),
    .res_nxt     (ch1_res)
  );

  dovfq_chan u_ch2 (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (advance && run_r && ch2_en_r),
    .cls         (ch2_cls),
    .volts       (ch2_v),
    .now_ms      (now_r),
    .volt_delay  (volt_delay_r),
    .short_delay (short_delay_r),
    .res_nxt     (ch2_res)
  );

  // result register
  logic      out_valid_r;
  chan_res_t ch1_out_r, ch2_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ch1_out_r <= ch1_res;
      ch2_out_r <= ch2_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ch1_fault = ch1_out_r.fault;
  assign out_ch2_fault = ch2_out_r.fault;
  assign out_ch1_volts = ch1_out_r.volts;
  assign out_ch2_volts = ch2_out_r.volts;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result dropped under stall");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced request did not produce a result");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("request accepted while both stages full and stalled");

endmodule

FILE: rtl/core/dovfq_chan.sv
// Per-channel fault persistence timer and latched fault code.
module dovfq_chan
  import dovfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      upd,
  input  code_t     cls,
  input  volts_t    volts,
  input  stamp_t    now_ms,
  input  delay_t    volt_delay,
  input  delay_t    short_delay,
  output chan_res_t res_nxt
);

  stamp_t stamp_r, stamp_nxt;
  logic   volt_pend_r, volt_pend_nxt;
  logic   short_pend_r, short_pend_nxt;
  code_t  latched_r, latched_nxt;
  volts_t volts_r, volts_nxt;
  stamp_t elapsed;

  assign elapsed = now_ms - stamp_r;

  always_comb begin
    stamp_nxt      = stamp_r;
    volt_pend_nxt  = volt_pend_r;
    short_pend_nxt = short_pend_r;
    latched_nxt    = latched_r;
    volts_nxt      = volts_r;
    if (upd) begin
      volts_nxt = volts;
      case (cls)
        CODE_VOLT: begin
          if (!volt_pend_r) begin
            stamp_nxt     = now_ms;
            volt_pend_nxt = 1'b1;
          end else if (elapsed > {{(TIME_W-DELAY_W){1'b0}}, volt_delay}) begin
            latched_nxt   = CODE_VOLT;
            volt_pend_nxt = 1'b0;
          end
        end
        CODE_SHORT: begin
          if (!short_pend_r) begin
            stamp_nxt      = now_ms;
            short_pend_nxt = 1'b1;
          end else if (elapsed > {{(TIME_W-DELAY_W){1'b0}}, short_delay}) begin
            latched_nxt    = CODE_SHORT;
            short_pend_nxt = 1'b0;
          end
        end
        default: begin
          if (latched_r == CODE_NONE) begin
            volt_pend_nxt  = 1'b0;
            short_pend_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r      <= '0;
      volt_pend_r  <= 1'b0;
      short_pend_r <= 1'b0;
      latched_r    <= CODE_NONE;
      volts_r      <= '0;
    end else begin
      stamp_r      <= stamp_nxt;
      volt_pend_r  <= volt_pend_nxt;
      short_pend_r <= short_pend_nxt;
      latched_r    <= latched_nxt;
      volts_r      <= volts_nxt;
    end
  end

  assign res_nxt.fault = latched_nxt;
  assign res_nxt.volts = volts_nxt;

  a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (latched_r != CODE_NONE) |=> (latched_r != CODE_NONE))
    else $error("latched fault returned to none");

  a_hold_no_upd: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> ($stable(latched_r) && $stable(stamp_r) && $stable(volts_r)))
    else $error("channel state changed without an update");

  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (latched_r == CODE_NONE) || (latched_r == CODE_VOLT) || (latched_r == CODE_SHORT))
    else $error("illegal latched code");

  a_stamp_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && (cls == CODE_SHORT) && !short_pend_r) |=> (stamp_r == $past(now_ms)))
    else $error("stamp not restarted when short becomes pending");

endmodule
